// ===== src/tubc_pkg.sv =====
// package for the ternary uniform block counter
// holds sizes, cell codes and the sequencer state type; no dependencies
`default_nettype none
package tubc_pkg;
    localparam int MaxOrder  = 4;
    localparam int MaxCells  = 6561;
    localparam int AddrW     = 13;
    localparam int CountW    = 13;
    localparam int OrderW    = 3;

    localparam logic [1:0] CodeMinus = 2'd0;
    localparam logic [1:0] CodeZero  = 2'd1;
    localparam logic [1:0] CodePlus  = 2'd2;
    localparam logic [1:0] CodeMixed = 2'd3;

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_FINAL = 5'b10000
    } state_t;

    // 3^k for k up to 8, narrow enough for the cell address
    function automatic logic [AddrW:0] pow3(input logic [3:0] k);
        logic [AddrW:0] r;
        r = (AddrW + 1)'(1);
        for (int i = 0; i < 8; i++)
            if (4'(i) < k)
                r = (AddrW + 1)'(r * 3);
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== src/ternary_uniform_block_counter_core.sv =====
// ternary uniform block counter top level
// uses tubc_pkg; holds the cell memory and the merge sequencer
`default_nettype none
// Cells are taken one per cycle, with no gap between them, while loading and no
// register write is under way. After the last cell the block merges the grid
// bottom-up, one level at a time, over one read and one write memory port:
// each parent takes nine reads, then a check and a write; a full order-4 grid
// merges 729+81+9+1 parents after its 6561 cells, then reads the root. The
// result then sits in an output register, and the next grid loads while it
// waits; a later result holds in its root step until that register is free.
module ternary_uniform_block_counter_core (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_we,
    input  wire [2:0]               cfg_wdata,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  wire signed [1:0]        cell_value,
    output logic                    out_valid,
    input  wire                     out_ready,
    output logic [12:0]             count_minus_one,
    output logic [12:0]             count_zero,
    output logic [12:0]             count_plus_one
);
    localparam int AW = tubc_pkg::AddrW;
    localparam int CW = tubc_pkg::CountW;

    logic [1:0] mem [tubc_pkg::MaxCells];
    logic [1:0] rd_reg;

    tubc_pkg::state_t state_reg, state_next;
    logic [2:0]    order_reg;
    logic [3:0]    eff_order;
    logic [AW-1:0] load_reg, load_next;
    logic [2:0]    lvl_reg, lvl_next;        // levels remaining
    logic [AW-1:0] side_reg, side_next;      // side of current child grid
    logic [AW-1:0] ns_reg, ns_next;          // parent grid side
    logic [AW-1:0] pi_reg, pi_next, pj_reg, pj_next;
    logic [AW-1:0] par_reg, par_next;        // parent write address
    logic [3:0]    k_reg, k_next;            // child number 0..8 (9 = last data)
    logic [1:0]    first_reg, first_next;
    logic          same_reg, same_next;
    logic [CW-1:0] cnt_reg [3];
    logic [CW-1:0] cnt_next [3];
    logic [CW-1:0] out_cnt_reg [3];
    logic          out_valid_reg, out_valid_next;
    logic          out_load;
    logic [AW+1:0] row_base_reg, row_base_next; // (3pi+a)*side + 3pj
    logic [1:0]    a_reg, a_next, b_reg, b_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [1:0]    kid [9];
    logic [1:0]    kid_reg [9];
    logic [AW-1:0] total_m1;
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [1:0]    mem_wd, code;

    assign eff_order = (order_reg > 3'(tubc_pkg::MaxOrder))
                       ? 4'(tubc_pkg::MaxOrder) : {1'b0, order_reg};
    assign total_m1 = AW'(tubc_pkg::pow3({eff_order[2:0], 1'b0}) - 1'b1);

    // value to code, -2 maps to minus
    always_comb
    begin
        unique case (cell_value)
            2'sd0:   code = tubc_pkg::CodeZero;
            2'sd1:   code = tubc_pkg::CodePlus;
            default: code = tubc_pkg::CodeMinus;
        endcase
    end

    assign in_ready = (state_reg == tubc_pkg::ST_LOAD) && !cfg_we;

    // memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_reg <= mem[mem_ra];
    end

    // collected children
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            kid[i] = kid_reg[i];
        if (rd_valid_reg)
            kid[k_reg - 4'd1] = rd_reg;
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        load_next     = load_reg;
        lvl_next      = lvl_reg;
        side_next     = side_reg;
        ns_next       = ns_reg;
        pi_next       = pi_reg;
        pj_next       = pj_reg;
        par_next      = par_reg;
        k_next        = k_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        first_next    = first_reg;
        same_next     = same_reg;
        row_base_next = row_base_reg;
        rd_valid_next = 1'b0;
        out_load      = 1'b0;
        for (int i = 0; i < 3; i++)
            cnt_next[i] = cnt_reg[i];
        mem_we = 1'b0;
        mem_wa = load_reg;
        mem_wd = code;
        mem_ra = AW'(row_base_reg + (AW+2)'(b_reg));
        unique case (state_reg)
            tubc_pkg::ST_LOAD:
            begin
                if (in_valid && in_ready)
                begin
                    mem_we = 1'b1;
                    if (load_reg == total_m1)
                    begin
                        load_next = '0;
                        for (int i = 0; i < 3; i++)
                            cnt_next[i] = '0;
                        lvl_next  = eff_order[2:0];
                        side_next = AW'(tubc_pkg::pow3(eff_order));
                        ns_next   = AW'(tubc_pkg::pow3(eff_order - 4'd1));
                        pi_next = '0; pj_next = '0; par_next = '0;
                        k_next = '0; a_next = '0; b_next = '0;
                        row_base_next = '0;
                        state_next = (eff_order == 4'd0) ? tubc_pkg::ST_FINAL
                                                         : tubc_pkg::ST_READ;
                    end
                    else
                        load_next = load_reg + 1'b1;
                end
            end
            tubc_pkg::ST_READ:
            begin
                // issue read of child k, capture child k-1
                rd_valid_next = 1'b1;
                k_next = k_reg + 4'd1;
                if (b_reg == 2'd2)
                begin
                    b_next = '0;
                    a_next = a_reg + 2'd1;
                    row_base_next = row_base_reg + (AW+2)'(side_reg);
                end
                else
                    b_next = b_reg + 2'd1;
                if (k_reg == 4'd8)
                    state_next = tubc_pkg::ST_CHECK;
            end
            tubc_pkg::ST_CHECK:
            begin
                same_next  = (kid[0] != tubc_pkg::CodeMixed);
                for (int i = 1; i < 9; i++)
                    if (kid[i] != kid[0])
                        same_next = 1'b0;
                first_next = kid[0];
                state_next = tubc_pkg::ST_WRITE;
            end
            tubc_pkg::ST_WRITE:
            begin
                mem_we = 1'b1;
                mem_wa = par_reg;
                mem_wd = same_reg ? first_reg : tubc_pkg::CodeMixed;
                if (!same_reg)
                    for (int i = 0; i < 9; i++)
                        if (kid_reg[i] != tubc_pkg::CodeMixed)
                            cnt_next[kid_reg[i]] = cnt_next[kid_reg[i]] + 1'b1;
                k_next = '0; a_next = '0; b_next = '0;
                par_next = par_reg + 1'b1;
                state_next = tubc_pkg::ST_READ;
                if (pj_reg == ns_reg - 1'b1)
                begin
                    pj_next = '0;
                    if (pi_reg == ns_reg - 1'b1)
                    begin
                        // level done
                        pi_next = '0;
                        par_next = '0;
                        lvl_next = lvl_reg - 3'd1;
                        side_next = ns_reg;
                        ns_next = AW'(tubc_pkg::pow3({1'b0, lvl_reg} - 4'd2));
                        row_base_next = '0;
                        if (lvl_reg == 3'd1)
                            state_next = tubc_pkg::ST_FINAL;
                    end
                    else
                    begin
                        pi_next = pi_reg + 1'b1;
                        row_base_next = (AW+2)'((pi_reg + 1'b1) * 3 * side_reg);
                    end
                end
                else
                begin
                    pj_next = pj_reg + 1'b1;
                    row_base_next = (AW+2)'(pi_reg * 3 * side_reg
                                             + (pj_reg + 1'b1) * 3);
                end
            end
            tubc_pkg::ST_FINAL:
            begin
                // root read issued on entry, held until the output register frees
                mem_ra = '0;
                rd_valid_next = 1'b1;
                if (rd_valid_reg && (!out_valid_reg || out_ready))
                begin
                    if (rd_reg != tubc_pkg::CodeMixed)
                        cnt_next[rd_reg] = cnt_reg[rd_reg] + 1'b1;
                    out_load = 1'b1;
                    rd_valid_next = 1'b0;
                    state_next = tubc_pkg::ST_LOAD;
                end
            end
            default: state_next = tubc_pkg::ST_LOAD;
        endcase
        if (cfg_we)
            load_next = '0;
    end

    // output register handshake
    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    // the row base product is small: pi*3*side < 6561
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tubc_pkg::ST_LOAD;
            order_reg     <= 3'd4;
            load_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                cnt_reg[i]     <= '0;
                out_cnt_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            load_reg      <= load_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
                cnt_reg[i] <= cnt_next[i];
            if (out_load)
                for (int i = 0; i < 3; i++)
                    out_cnt_reg[i] <= cnt_next[i];
            if (cfg_we)
                order_reg <= cfg_wdata;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        lvl_reg      <= lvl_next;
        side_reg     <= side_next;
        ns_reg       <= ns_next;
        pi_reg       <= pi_next;
        pj_reg       <= pj_next;
        par_reg      <= par_next;
        k_reg        <= k_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        first_reg    <= first_next;
        same_reg     <= same_next;
        row_base_reg <= row_base_next;
        for (int i = 0; i < 9; i++)
            kid_reg[i] <= kid[i];
    end

    assign out_valid       = out_valid_reg;
    assign count_minus_one = out_cnt_reg[0];
    assign count_zero      = out_cnt_reg[1];
    assign count_plus_one  = out_cnt_reg[2];

    // checks
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != tubc_pkg::ST_LOAD) |-> !in_ready)
        else $error("input taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(count_zero)))
        else $error("result dropped");
    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        load_reg <= total_m1 || $past(cfg_we))
        else $error("load index out of range");
endmodule
`default_nettype wire

// ===== verif/tb_ternary_uniform_block_counter_core.sv =====
// testbench for the ternary uniform block counter core
// depends on src/tubc_pkg.sv and src/ternary_uniform_block_counter_core.sv
`timescale 1ns / 1ps
module tb_ternary_uniform_block_counter_core;

    localparam int WatchLimit = 200000;
    localparam int HoldCycles = 400;

    typedef struct packed {
        logic [tubc_pkg::CountW-1:0] minus_cnt;
        logic [tubc_pkg::CountW-1:0] zero_cnt;
        logic [tubc_pkg::CountW-1:0] plus_cnt;
    } piece_counts_t;

    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_wdata;
    logic               in_valid;
    wire                in_ready;
    logic [1:0]         cell_value;
    wire                out_valid;
    logic               out_ready;
    wire [tubc_pkg::CountW-1:0]   count_minus_one;
    wire [tubc_pkg::CountW-1:0]   count_zero;
    wire [tubc_pkg::CountW-1:0]   count_plus_one;

    ternary_uniform_block_counter_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .cell_value(cell_value),
        .out_valid(out_valid), .out_ready(out_ready),
        .count_minus_one(count_minus_one), .count_zero(count_zero),
        .count_plus_one(count_plus_one)
    );

    // mirror of the block state
    logic [2:0]         mirror_order;
    logic [1:0]         grid_codes [tubc_pkg::MaxCells];
    logic [1:0]         merge_buf [tubc_pkg::MaxCells];
    int                 cells_loaded;
    piece_counts_t      expected_counts [$];

    logic [1:0]         pending_cells [$];
    logic [1:0]         grid_buf [tubc_pkg::MaxCells];
    idle_mode_t         idle_mode;
    int                 hold_left;
    int                 hold_request;
    bit                 cell_taken;
    int                 errors;
    int                 quiet_cycles;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // bottom-up merge of the loaded grid into per-value piece counts
    function automatic piece_counts_t count_pieces(input int order);
        piece_counts_t pc;
        int side, ns, pi, pj, a, b;
        logic [1:0] first, c;
        bit same;
        pc = '0;
        side = 3 ** order;
        for (int i = 0; i < side * side; i++)
            merge_buf[i] = grid_codes[i];
        for (int lvl = 0; lvl < order; lvl++)
        begin
            ns = side / 3;
            for (pi = 0; pi < ns; pi++)
                for (pj = 0; pj < ns; pj++)
                begin
                    first = merge_buf[(3 * pi) * side + 3 * pj];
                    same = (first != tubc_pkg::CodeMixed);
                    for (a = 0; a < 3; a++)
                        for (b = 0; b < 3; b++)
                            if (merge_buf[(3 * pi + a) * side + 3 * pj + b] != first)
                                same = 0;
                    if (!same)
                    begin
                        for (a = 0; a < 3; a++)
                            for (b = 0; b < 3; b++)
                            begin
                                c = merge_buf[(3 * pi + a) * side + 3 * pj + b];
                                if (c == tubc_pkg::CodeMinus) pc.minus_cnt++;
                                else if (c == tubc_pkg::CodeZero) pc.zero_cnt++;
                                else if (c == tubc_pkg::CodePlus) pc.plus_cnt++;
                            end
                        first = tubc_pkg::CodeMixed;
                    end
                    merge_buf[pi * ns + pj] = first;
                end
            side = ns;
        end
        if (merge_buf[0] == tubc_pkg::CodeMinus) pc.minus_cnt++;
        else if (merge_buf[0] == tubc_pkg::CodeZero) pc.zero_cnt++;
        else if (merge_buf[0] == tubc_pkg::CodePlus) pc.plus_cnt++;
        return pc;
    endfunction

    // take one accepted cell into the mirror
    task automatic absorb_cell(input logic [1:0] raw);
        int order, total;
        logic [1:0] code;
        order = (mirror_order > tubc_pkg::MaxOrder) ? tubc_pkg::MaxOrder
                                                     : int'(mirror_order);
        total = (3 ** order) * (3 ** order);
        if (raw == 2'b00) code = tubc_pkg::CodeZero;
        else if (raw == 2'b01) code = tubc_pkg::CodePlus;
        else code = tubc_pkg::CodeMinus;
        if (cells_loaded >= total)
            cells_loaded = 0;
        grid_codes[cells_loaded] = code;
        cells_loaded++;
        if (cells_loaded == total)
        begin
            expected_counts.push_back(count_pieces(order));
            cells_loaded = 0;
        end
    endtask

    // random pattern for a value; minus one sometimes as the out-of-range pattern
    function automatic logic [1:0] pattern_of(input int v);
        if (v == 0) return 2'b00;
        if (v == 1) return 2'b01;
        return ($urandom_range(3) == 0) ? 2'b10 : 2'b11;
    endfunction

    // recursive grid builder: squares go uniform with a given chance
    function automatic void build_square(input int r, input int c, input int sz,
                                         input int side, input int uni_pct);
        int v;
        if (sz == 1 || $urandom_range(99) < uni_pct)
        begin
            v = $urandom_range(2) - 1;
            for (int i = 0; i < sz; i++)
                for (int j = 0; j < sz; j++)
                    grid_buf[(r + i) * side + c + j] = pattern_of(v);
        end
        else
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    build_square(r + i * sz / 3, c + j * sz / 3, sz / 3, side, uni_pct);
    endfunction

    // queue one structured grid, with a little cell noise
    task automatic queue_grid(input int order, input int uni_pct, input int noise_pct);
        int side;
        side = 3 ** order;
        build_square(0, 0, side, side, uni_pct);
        for (int i = 0; i < side * side; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                pending_cells.push_back(2'($urandom_range(3)));
            else
                pending_cells.push_back(grid_buf[i]);
        end
    endtask

    // wait for the input side to drain and every result to come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cells.size() != 0 || in_valid || expected_counts.size() != 0
               || hold_left != 0);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_order(input logic [2:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        mirror_order = v;
        cells_loaded = 0;
    endtask

    // sample accepted cells
    always @(posedge clk)
    begin
        cell_taken = in_valid && in_ready;
        if (cell_taken)
            absorb_cell(cell_value);
    end

    // cell driver
    always @(negedge clk)
    begin
        if (in_valid && !cell_taken)
            in_valid <= 1'b1;
        else if (pending_cells.size() != 0 &&
                 !((idle_mode == IDLE_TX || idle_mode == IDLE_BOTH) &&
                   $urandom_range(99) < ((idle_mode == IDLE_TX) ? 83 : 28)))
        begin
            in_valid <= 1'b1;
            cell_value <= pending_cells.pop_front();
        end
        else
            in_valid <= 1'b0;
    end

    // result receiver with random stalls and a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if ((idle_mode == IDLE_RX || idle_mode == IDLE_BOTH) &&
                 $urandom_range(99) < ((idle_mode == IDLE_RX) ? 83 : 28))
            out_ready <= 1'b0;
        else
            out_ready <= 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        piece_counts_t want;
        if (out_valid && out_ready)
        begin
            if (expected_counts.size() == 0)
            begin
                $display("%0t: unexpected result %0d %0d %0d", $time,
                         count_minus_one, count_zero, count_plus_one);
                errors++;
            end
            else
            begin
                want = expected_counts.pop_front();
                if (count_minus_one !== want.minus_cnt)
                begin
                    $display("%0t: count_minus_one expected %0d actual %0d", $time,
                             want.minus_cnt, count_minus_one);
                    errors++;
                end
                if (count_zero !== want.zero_cnt)
                begin
                    $display("%0t: count_zero expected %0d actual %0d", $time,
                             want.zero_cnt, count_zero);
                    errors++;
                end
                if (count_plus_one !== want.plus_cnt)
                begin
                    $display("%0t: count_plus_one expected %0d actual %0d", $time,
                             want.plus_cnt, count_plus_one);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item moving
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int rand_items, phase_items, order, pick, phase_no;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 3'd0;
        in_valid = 1'b0;
        cell_value = 2'b00;
        out_ready = 1'b0;
        idle_mode = IDLE_NONE;
        hold_left = 0;
        hold_request = 0;
        cell_taken = 0;
        errors = 0;
        quiet_cycles = 0;
        mirror_order = 3'd4;
        cells_loaded = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // reset order is the largest grid: a partial load gives no result
        for (int i = 0; i < 100; i++)
            pending_cells.push_back(2'($urandom_range(3)));
        wait_drained();

        // single-cell grids, every value and the out-of-range pattern
        write_order(3'd0);
        pending_cells.push_back(2'b11);
        pending_cells.push_back(2'b00);
        pending_cells.push_back(2'b01);
        pending_cells.push_back(2'b10);
        wait_drained();

        // all-zero order-1 grid, then a load cut short by a register write
        write_order(3'd1);
        for (int i = 0; i < 9; i++)
            pending_cells.push_back(2'b00);
        for (int i = 0; i < 5; i++)
            pending_cells.push_back(2'b01);
        wait_drained();
        write_order(3'd1);
        for (int i = 0; i < 9; i++)
            pending_cells.push_back(2'($urandom_range(3)));
        wait_drained();

        // order above the maximum saturates: more cells than an order-3 grid, no result
        write_order(3'd7);
        for (int i = 0; i < 760; i++)
            pending_cells.push_back(2'b01);
        wait_drained();

        // receiver holds off while single-cell grids pile up
        write_order(3'd0);
        hold_request = HoldCycles;
        for (int i = 0; i < 40; i++)
            pending_cells.push_back(2'($urandom_range(3)));
        wait_drained();

        // random phases of structured grids
        rand_items = 0;
        phase_no = 0;
        while (rand_items < 800)
        begin
            idle_mode = idle_mode_t'(phase_no % 4);
            pick = $urandom_range(99);
            order = (pick < 10) ? 0 : (pick < 45) ? 1 : (pick < 88) ? 2 : 3;
            write_order(3'(order));
            phase_items = 0;
            while (phase_items < 150)
            begin
                queue_grid(order, 15 * $urandom_range(6), ($urandom_range(3) == 0) ? 10 : 0);
                phase_items += (3 ** order) * (3 ** order);
            end
            rand_items += phase_items;
            wait_drained();
            phase_no++;
        end

        idle_mode = IDLE_NONE;
        repeat (200) @(negedge clk);
        if (errors == 0 && expected_counts.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
